>>> rtl/fqpr_pkg.sv
package fqpr_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // Input tdata layout, lowest bit first: command, item_value, reverse_count.
    localparam int IN_CMD_LSB   = 0;
    localparam int IN_VALUE_LSB = IN_CMD_LSB + CMD_W;
    localparam int IN_K_LSB     = IN_VALUE_LSB + VALUE_W;
    localparam int IN_USED_W    = IN_K_LSB + COUNT_W;
    localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

    // Output tdata layout, lowest bit first: head_value, entry_count, op_status.
    localparam int OUT_HEAD_LSB   = 0;
    localparam int OUT_COUNT_LSB  = OUT_HEAD_LSB + VALUE_W;
    localparam int OUT_STATUS_LSB = OUT_COUNT_LSB + COUNT_W;
    localparam int OUT_USED_W     = OUT_STATUS_LSB + STATUS_W;
    localparam int OUT_TDATA_W    = ((OUT_USED_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REV = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BADK  = 2'd3;

    localparam logic [VALUE_W-1:0] HEAD_EMPTY = 32'hFFFF_FFFF;

endpackage

>>> rtl/fifo_queue_with_prefix_reverse.sv
// Enqueue, dequeue and rejected commands go from S_IDLE through S_HEAD, which reads the head
// entry, to S_FIN, which loads their result into the output register once it is free.
// A reverse of K entries runs floor(K / 2) swaps (S_RDA to S_WRB) first; each swap reads and
// writes both entries through the one read port of the entry RAM and the shared ring adder.
// A new transaction is accepted once the previous result sits in the output register.
// Reset (synchronous, aresetn low) empties the queue and the output; RAM words are kept.
module fifo_queue_with_prefix_reverse #(
    parameter int DEPTH = fqpr_pkg::DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // command [1:0], item_value [33:2], reverse_count [38:34], zero pad above
    input  logic [fqpr_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // head_value [31:0], entry_count [36:32], op_status [38:37], zero pad above
    output logic [fqpr_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    localparam int AW   = $clog2(DEPTH);
    localparam int AW1  = AW + 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int KW   = fqpr_pkg::COUNT_W;
    localparam int CMPW = (CW > KW) ? CW : KW;
    localparam int VW   = fqpr_pkg::VALUE_W;
    localparam int SW   = fqpr_pkg::STATUS_W;
    localparam int OW   = fqpr_pkg::OUT_TDATA_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RDA  = 7'b0000010,
        S_RDB  = 7'b0000100,
        S_WRA  = 7'b0001000,
        S_WRB  = 7'b0010000,
        S_HEAD = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     lo_reg, lo_next;
    logic [AW-1:0]     hi_reg, hi_next;
    logic [SW-1:0]     status_reg, status_next;
    logic [VW-1:0]     tmp_reg, tmp_next;
    logic              m_valid_reg, m_valid_next;
    logic [OW-1:0]     m_data_reg, m_data_next;

    logic [fqpr_pkg::CMD_W-1:0] in_cmd;
    logic [VW-1:0]     in_value;
    logic [CMPW-1:0]   k_x;
    logic [CMPW-1:0]   cnt_x;

    logic [AW-1:0]     ring_off;
    logic [AW-1:0]     ring_pos;

    logic              ram_we;
    logic [VW-1:0]     ram_wdata;
    logic              ram_re;
    logic [VW-1:0]     ram_rdata;
    logic              out_load;
    logic [VW-1:0]     head_out;

    assign in_cmd   = s_tdata[fqpr_pkg::IN_CMD_LSB +: fqpr_pkg::CMD_W];
    assign in_value = s_tdata[fqpr_pkg::IN_VALUE_LSB +: VW];
    assign k_x      = CMPW'(s_tdata[fqpr_pkg::IN_K_LSB +: KW]);
    assign cnt_x    = CMPW'(count_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    fqpr_ring_addr #(
        .DEPTH (DEPTH)
    ) u_ring_addr (
        .head   (head_reg),
        .offset (ring_off),
        .pos    (ring_pos)
    );

    fqpr_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ring_pos),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ring_pos),
        .rdata (ram_rdata)
    );

    // The single ring adder is steered by the sequencer state.
    always_comb begin
        ring_off = '0;
        unique case (state_reg)
            S_IDLE: begin
                ring_off = (in_cmd == fqpr_pkg::CMD_DEQ) ? AW'(1) : AW'(count_reg);
            end
            S_RDA, S_WRA: ring_off = lo_reg;
            S_RDB, S_WRB: ring_off = hi_reg;
            default:      ring_off = '0;
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        status_next = status_reg;
        tmp_next    = tmp_reg;
        ram_we      = 1'b0;
        ram_wdata   = in_value;
        ram_re      = 1'b0;
        out_load    = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    status_next = fqpr_pkg::STAT_DONE;
                    state_next  = S_HEAD;
                    priority if (in_cmd == fqpr_pkg::CMD_ENQ) begin
                        if (cnt_x == CMPW'(DEPTH)) begin
                            status_next = fqpr_pkg::STAT_FULL;
                        end else begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end else if (in_cmd == fqpr_pkg::CMD_DEQ) begin
                        if (count_reg == '0) begin
                            status_next = fqpr_pkg::STAT_EMPTY;
                        end else begin
                            head_next  = ring_pos;
                            count_next = count_reg - CW'(1);
                        end
                    end else if (in_cmd == fqpr_pkg::CMD_REV) begin
                        if (k_x <= CMPW'(1) || k_x > cnt_x) begin
                            status_next = fqpr_pkg::STAT_BADK;
                        end else begin
                            lo_next    = '0;
                            hi_next    = AW'(k_x - CMPW'(1));
                            state_next = S_RDA;
                        end
                    end else begin
                        status_next = fqpr_pkg::STAT_DONE;
                    end
                end
            end
            S_RDA: begin
                ram_re     = 1'b1;
                state_next = S_RDB;
            end
            S_RDB: begin
                ram_re     = 1'b1;
                tmp_next   = ram_rdata;
                state_next = S_WRA;
            end
            S_WRA: begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                state_next = S_WRB;
            end
            S_WRB: begin
                ram_we    = 1'b1;
                ram_wdata = tmp_reg;
                lo_next   = lo_reg + AW'(1);
                hi_next   = hi_reg - AW'(1);
                // Another pair remains while the moved pointers have not met.
                if (({1'b0, lo_reg} + AW1'(2)) < {1'b0, hi_reg}) begin
                    state_next = S_RDA;
                end else begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD: begin
                ram_re     = 1'b1;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        head_out = (count_reg == '0) ? fqpr_pkg::HEAD_EMPTY : ram_rdata;
        m_data_next = m_data_reg;
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            m_data_next[fqpr_pkg::OUT_HEAD_LSB +: VW]   = head_out;
            m_data_next[fqpr_pkg::OUT_COUNT_LSB +: KW]  = cnt_x[KW-1:0];
            m_data_next[fqpr_pkg::OUT_STATUS_LSB +: SW] = status_reg;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        status_reg <= status_next;
        tmp_reg    <= tmp_next;
        m_data_reg <= m_data_next;
    end

endmodule

>>> rtl/fqpr_ram.sv
module fqpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/fqpr_ring_addr.sv
module fqpr_ring_addr #(
    parameter int DEPTH = fqpr_pkg::DEPTH_DEFAULT
) (
    input  logic [$clog2(DEPTH)-1:0] head,
    input  logic [$clog2(DEPTH)-1:0] offset,
    output logic [$clog2(DEPTH)-1:0] pos
);

    localparam int AW  = $clog2(DEPTH);
    localparam int AW1 = AW + 1;

    logic [AW:0] sum;

    // Both operands stay below DEPTH, so one conditional subtract wraps the ring.
    always_comb begin
        sum = {1'b0, head} + {1'b0, offset};
        if (sum >= AW1'(DEPTH)) begin
            pos = AW'(sum - AW1'(DEPTH));
        end else begin
            pos = sum[AW-1:0];
        end
    end

endmodule

>>> rtl/fqpr_checker.sv
module fqpr_checker #(
    parameter int DEPTH = fqpr_pkg::DEPTH_DEFAULT
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [fqpr_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    logic [fqpr_pkg::VALUE_W-1:0]  out_head;
    logic [fqpr_pkg::COUNT_W-1:0]  out_count;
    logic [fqpr_pkg::STATUS_W-1:0] out_status;

    assign out_head   = m_tdata[fqpr_pkg::OUT_HEAD_LSB +: fqpr_pkg::VALUE_W];
    assign out_count  = m_tdata[fqpr_pkg::OUT_COUNT_LSB +: fqpr_pkg::COUNT_W];
    assign out_status = m_tdata[fqpr_pkg::OUT_STATUS_LSB +: fqpr_pkg::STATUS_W];

    // A held result must not change before it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The block works on one transaction at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a command is in progress");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_status == fqpr_pkg::STAT_FULL |-> out_count == DEPTH[4:0])
        else $error("full rejection reported with a count below the depth");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_status == fqpr_pkg::STAT_EMPTY |-> out_count == '0)
        else $error("empty dequeue reported with a nonzero count");

    a_empty_head: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_count == '0 && DEPTH < 32 |-> out_head == fqpr_pkg::HEAD_EMPTY)
        else $error("empty queue reported a head value other than all ones");

endmodule

bind fifo_queue_with_prefix_reverse fqpr_checker #(
    .DEPTH (DEPTH)
) u_fqpr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> sim/tb_fifo_queue_with_prefix_reverse.sv
module tb_fifo_queue_with_prefix_reverse;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH = fqpr_pkg::DEPTH_DEFAULT;
    localparam int KW = fqpr_pkg::COUNT_W;
    // Command code 3 carries no operation; the queue must leave everything alone.
    localparam logic [fqpr_pkg::CMD_W-1:0] CMD_NONE = 2'd3;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    // Long enough to cover the longest reverse (K = 16).
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [fqpr_pkg::VALUE_W-1:0]  head;
        logic [fqpr_pkg::COUNT_W-1:0]  count;
        logic [fqpr_pkg::STATUS_W-1:0] status;
    } queue_result_t;

    typedef struct packed {
        logic [fqpr_pkg::CMD_W-1:0]    cmd;
        logic [fqpr_pkg::VALUE_W-1:0]  value;
        logic [fqpr_pkg::COUNT_W-1:0]  k;
        bit                            typed;
        queue_result_t                 result;
    } directed_row_t;

    localparam int N_DIRECTED = 26;
    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{fqpr_pkg::CMD_DEQ, 32'h0000_0000, 5'd0,  1'b1,
          '{fqpr_pkg::HEAD_EMPTY, 5'd0, fqpr_pkg::STAT_EMPTY}},
        '{fqpr_pkg::CMD_REV, 32'h0000_0000, 5'd2,  1'b1,
          '{fqpr_pkg::HEAD_EMPTY, 5'd0, fqpr_pkg::STAT_BADK}},
        '{fqpr_pkg::CMD_ENQ, 32'h7FFF_FFFF, 5'd0,  1'b1,
          '{32'h7FFF_FFFF, 5'd1, fqpr_pkg::STAT_DONE}},
        '{fqpr_pkg::CMD_ENQ, 32'h8000_0000, 5'd0,  1'b1,
          '{32'h7FFF_FFFF, 5'd2, fqpr_pkg::STAT_DONE}},
        '{fqpr_pkg::CMD_REV, 32'h0000_0000, 5'd1,  1'b1,
          '{32'h7FFF_FFFF, 5'd2, fqpr_pkg::STAT_BADK}},
        '{fqpr_pkg::CMD_REV, 32'h0000_0000, 5'd0,  1'b1,
          '{32'h7FFF_FFFF, 5'd2, fqpr_pkg::STAT_BADK}},
        '{fqpr_pkg::CMD_REV, 32'h0000_0000, 5'd31, 1'b1,
          '{32'h7FFF_FFFF, 5'd2, fqpr_pkg::STAT_BADK}},
        '{fqpr_pkg::CMD_REV, 32'h0000_0000, 5'd2,  1'b1,
          '{32'h8000_0000, 5'd2, fqpr_pkg::STAT_DONE}},
        '{CMD_NONE,          32'hFFFF_FFFF, 5'd31, 1'b1,
          '{32'h8000_0000, 5'd2, fqpr_pkg::STAT_DONE}},
        '{fqpr_pkg::CMD_ENQ, 32'h0000_0000, 5'd0,  1'b0, '0},
        '{fqpr_pkg::CMD_ENQ, 32'hFFFF_FFFF, 5'd0,  1'b0, '0},
        '{fqpr_pkg::CMD_ENQ, 32'h0000_0001, 5'd0,  1'b0, '0},
        '{fqpr_pkg::CMD_ENQ, 32'h5555_5555, 5'd0,  1'b0, '0},
        '{fqpr_pkg::CMD_ENQ, 32'hAAAA_AAAA, 5'd0,  1'b0, '0},
        '{fqpr_pkg::CMD_ENQ, 32'h0000_0005, 5'd0,  1'b0, '0},
        '{fqpr_pkg::CMD_ENQ, 32'h0000_0006, 5'd0,  1'b0, '0},
        '{fqpr_pkg::CMD_ENQ, 32'h0000_0007, 5'd0,  1'b0, '0},
        '{fqpr_pkg::CMD_ENQ, 32'h0000_0008, 5'd0,  1'b0, '0},
        '{fqpr_pkg::CMD_ENQ, 32'h0000_0009, 5'd0,  1'b0, '0},
        '{fqpr_pkg::CMD_ENQ, 32'h0000_000A, 5'd0,  1'b0, '0},
        '{fqpr_pkg::CMD_ENQ, 32'h0000_000B, 5'd0,  1'b0, '0},
        '{fqpr_pkg::CMD_ENQ, 32'h0000_000C, 5'd0,  1'b0, '0},
        '{fqpr_pkg::CMD_ENQ, 32'h0000_000D, 5'd0,  1'b0, '0},
        '{fqpr_pkg::CMD_ENQ, 32'h1234_5678, 5'd0,  1'b1,
          '{32'h8000_0000, 5'd16, fqpr_pkg::STAT_FULL}},
        '{fqpr_pkg::CMD_REV, 32'h0000_0000, 5'd16, 1'b0, '0},
        '{fqpr_pkg::CMD_DEQ, 32'h0000_0000, 5'd0,  1'b0, '0}
    };

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [fqpr_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [fqpr_pkg::OUT_TDATA_W-1:0] m_tdata;

    fifo_queue_with_prefix_reverse dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state: the ring contents, head position and fill level.
    logic [fqpr_pkg::VALUE_W-1:0] ring_store [QDEPTH];
    logic [3:0]                   ring_head;
    logic [fqpr_pkg::COUNT_W-1:0] ring_held;

    queue_result_t pending_results [$];

    int errors = 0;
    int results_checked = 0;
    int n_reversed = 0;
    int n_full = 0;
    int n_empty = 0;
    int n_badk = 0;
    int peak_held = 0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_asks = 0;
    int stall_seen = 0;
    int stall_left = 0;
    int idle_cycles = 0;

    queue_result_t got;
    queue_result_t want;

    task automatic queue_step(input logic [fqpr_pkg::CMD_W-1:0] cmd,
                              input logic [fqpr_pkg::VALUE_W-1:0] value,
                              input logic [fqpr_pkg::COUNT_W-1:0] k,
                              output queue_result_t r);
        int lo;
        int hi;
        logic [3:0] a;
        logic [3:0] b;
        logic [fqpr_pkg::VALUE_W-1:0] t;
        r.status = fqpr_pkg::STAT_DONE;
        case (cmd)
            fqpr_pkg::CMD_ENQ: begin
                if (ring_held >= QDEPTH) begin
                    r.status = fqpr_pkg::STAT_FULL;
                end else begin
                    a = ring_head + ring_held[3:0];
                    ring_store[a] = value;
                    ring_held++;
                end
            end
            fqpr_pkg::CMD_DEQ: begin
                if (ring_held == 0) begin
                    r.status = fqpr_pkg::STAT_EMPTY;
                end else begin
                    ring_head++;
                    ring_held--;
                end
            end
            fqpr_pkg::CMD_REV: begin
                if (k <= 1 || k > ring_held) begin
                    r.status = fqpr_pkg::STAT_BADK;
                end else begin
                    lo = 0;
                    hi = k - 1;
                    while (lo < hi) begin
                        a = ring_head + lo[3:0];
                        b = ring_head + hi[3:0];
                        t = ring_store[a];
                        ring_store[a] = ring_store[b];
                        ring_store[b] = t;
                        lo++;
                        hi--;
                    end
                end
            end
            default: begin
            end
        endcase
        r.head = (ring_held == 0) ? fqpr_pkg::HEAD_EMPTY : ring_store[ring_head];
        r.count = ring_held;
    endtask

    function automatic logic [fqpr_pkg::IN_TDATA_W-1:0] pack_command(
            input logic [fqpr_pkg::CMD_W-1:0] cmd,
            input logic [fqpr_pkg::VALUE_W-1:0] value,
            input logic [fqpr_pkg::COUNT_W-1:0] k);
        logic [fqpr_pkg::IN_TDATA_W-1:0] word;
        word = '0;
        word[fqpr_pkg::IN_CMD_LSB +: fqpr_pkg::CMD_W] = cmd;
        word[fqpr_pkg::IN_VALUE_LSB +: fqpr_pkg::VALUE_W] = value;
        word[fqpr_pkg::IN_K_LSB +: fqpr_pkg::COUNT_W] = k;
        return word;
    endfunction

    // Entered and left at a falling edge; tvalid stays high for the next command.
    task automatic send_command(input logic [fqpr_pkg::CMD_W-1:0] cmd,
                                input logic [fqpr_pkg::VALUE_W-1:0] value,
                                input logic [fqpr_pkg::COUNT_W-1:0] k, input bit typed,
                                input queue_result_t typed_result);
        queue_result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = pack_command(cmd, value, k);
        do @(posedge aclk); while (!s_tready);
        queue_step(cmd, value, k, r);
        pending_results.push_back(typed ? typed_result : r);
        case (r.status)
            fqpr_pkg::STAT_FULL:  n_full++;
            fqpr_pkg::STAT_EMPTY: n_empty++;
            fqpr_pkg::STAT_BADK:  n_badk++;
            default:              if (cmd == fqpr_pkg::CMD_REV) n_reversed++;
        endcase
        if (r.count > peak_held) peak_held = r.count;
        @(negedge aclk);
    endtask

    task automatic wait_for_results();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    // Alternates between filling and draining stretches so both full and empty are reached.
    task automatic send_random(input int count);
        logic [fqpr_pkg::CMD_W-1:0] cmd;
        logic [fqpr_pkg::COUNT_W-1:0] k;
        int roll;
        int enq_weight;
        for (int n = 0; n < count; n++) begin
            enq_weight = ((n / 40) % 2 == 0) ? 55 : 25;
            roll = $urandom_range(99);
            k = KW'($urandom_range(31, 0));
            if (roll < enq_weight) begin
                cmd = fqpr_pkg::CMD_ENQ;
            end else if (roll < enq_weight + 30) begin
                cmd = fqpr_pkg::CMD_DEQ;
            end else if (roll < 94) begin
                cmd = fqpr_pkg::CMD_REV;
                if (ring_held >= 2 && $urandom_range(9) < 7) begin
                    k = KW'($urandom_range(ring_held, 2));
                end
            end else begin
                cmd = CMD_NONE;
            end
            send_command(cmd, $urandom(), k, 1'b0, '0);
        end
    endtask

    always @(negedge aclk) begin
        if (stall_asks != stall_seen) begin
            stall_seen = stall_asks;
            stall_left = HOLD_OFF_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready = 1'b0;
        end else begin
            m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.head = m_tdata[fqpr_pkg::OUT_HEAD_LSB +: fqpr_pkg::VALUE_W];
            got.count = m_tdata[fqpr_pkg::OUT_COUNT_LSB +: fqpr_pkg::COUNT_W];
            got.status = m_tdata[fqpr_pkg::OUT_STATUS_LSB +: fqpr_pkg::STATUS_W];
            if (pending_results.size() == 0) begin
                $display("%0t: result with no command outstanding: head %h count %0d status %0d",
                         $time, got.head, got.count, got.status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.head !== want.head) begin
                    $display("%0t: head_value expected %h, got %h", $time, want.head, got.head);
                    errors++;
                end
                if (got.count !== want.count) begin
                    $display("%0t: entry_count expected %0d, got %0d",
                             $time, want.count, got.count);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: op_status expected %0d, got %0d",
                             $time, want.status, got.status);
                    errors++;
                end
            end
        end
    end

    // Watchdog: a long stretch with no transaction on either side means the block hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, WATCHDOG_LIMIT, pending_results.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        ring_head = '0;
        ring_held = '0;
        for (int i = 0; i < QDEPTH; i++) ring_store[i] = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_idle_pct = 19;
        recv_idle_pct = 49;
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_command(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].k,
                         DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);
        end
        send_random(130);
        wait_for_results();

        send_idle_pct = 49;
        recv_idle_pct = 19;
        send_random(130);

        // The receiver holds off while commands keep coming, so the input backs up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_asks++;
        send_random(140);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("Checked %0d results: %0d reversals, %0d rejected enqueues when full,",
                 results_checked, n_reversed, n_full);
        $display("%0d dequeues on empty, %0d invalid reverse counts, peak fill %0d of %0d.",
                 n_empty, n_badk, peak_held, QDEPTH);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
